// ===== design/assert_macros.svh =====
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Expression must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, clk, rstn, expr) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) \
        else $error("assertion failed");
// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");
// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rstn, expr)
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons)
`define ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

// ===== design/esd_pkg.sv =====
// Types, codes and the CRC-32 byte step for the event stream deframer.
package esd_pkg;

    localparam logic [1:0] KIND_NAME    = 2'd0;
    localparam logic [1:0] KIND_VALUE   = 2'd1;
    localparam logic [1:0] KIND_PAYLOAD = 2'd2;
    localparam logic [1:0] KIND_STATUS  = 2'd3;

    localparam logic [2:0] STATUS_OK        = 3'd0;
    localparam logic [2:0] STATUS_SHORT     = 3'd1;
    localparam logic [2:0] STATUS_PRELUDE   = 3'd2;
    localparam logic [2:0] STATUS_MSG_CRC   = 3'd3;
    localparam logic [2:0] STATUS_MALFORMED = 3'd4;

    localparam logic [32:0] MIN_MESSAGE_LEN = 33'd16;
    localparam logic [31:0] PRELUDE_LEN     = 32'd12;
    localparam logic [31:0] CRC_ALL_ONES    = 32'hffff_ffff;
    localparam logic [31:0] CRC_POLY        = 32'hedb8_8320;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic [7:0] hdr_type;
        logic       field_end;
        logic [2:0] status;
        logic       last;
    } result_t;

    // Up to two results from one accepted item, first in order first.
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

    // Reflected CRC-32, one byte.
    function automatic logic [31:0] crc32_byte(input logic [31:0] crc_in,
                                               input logic [7:0]  data);
        logic [31:0] c;
        c = crc_in ^ {24'd0, data};
        for (int i = 0; i < 8; i++) begin
            c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
        end
        return c;
    endfunction

endpackage

// ===== design/esd_parser.sv =====
// Delay window, CRC and header parsing; produces up to two results per item.
module esd_parser (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             accept,
    input  logic [7:0]       data_byte,
    input  logic             end_of_message,
    output esd_pkg::push_t   push
);

    typedef enum logic [2:0] {
        PH_NAME_LEN,
        PH_NAME,
        PH_TYPE,
        PH_VLEN_HI,
        PH_VLEN_LO,
        PH_VALUE
    } phase_t;

    logic [31:0] pos_reg,   pos_next;
    logic [7:0]  win_reg [4];
    logic [7:0]  win_next [4];
    logic [2:0]  fill_reg,  fill_next;
    logic [31:0] crc_reg,   crc_next;
    logic [31:0] pcalc_reg, pcalc_next;
    logic [31:0] precv_reg, precv_next;
    logic [31:0] hlen_reg,  hlen_next;
    phase_t      phase_reg, phase_next;
    logic [15:0] rem_reg,   rem_next;
    logic [7:0]  type_reg,  type_next;
    logic        herr_reg,  herr_next;

    logic [7:0]      leaving;
    logic [31:0]     rel;
    logic [15:0]     vlen;
    logic [32:0]     size;
    logic [32:0]     hdr_end;
    logic [31:0]     recv;
    logic            byte_out;
    esd_pkg::result_t byte_res;
    esd_pkg::result_t stat_res;

    always_comb begin
        pos_next   = pos_reg;
        win_next   = win_reg;
        fill_next  = fill_reg;
        crc_next   = crc_reg;
        pcalc_next = pcalc_reg;
        precv_next = precv_reg;
        hlen_next  = hlen_reg;
        phase_next = phase_reg;
        rem_next   = rem_reg;
        type_next  = type_reg;
        herr_next  = herr_reg;
        leaving    = win_reg[0];
        rel        = pos_reg - esd_pkg::PRELUDE_LEN;
        vlen       = {rem_reg[15:8], data_byte};
        byte_out   = 1'b0;
        byte_res   = '0;

        if (fill_reg[2]) begin
            vlen        = {rem_reg[15:8], leaving};
            win_next[0] = win_reg[1];
            win_next[1] = win_reg[2];
            win_next[2] = win_reg[3];
            win_next[3] = data_byte;
            crc_next    = esd_pkg::crc32_byte(crc_reg, leaving);
            if (pos_reg < 32'd4) begin
                // total length: covered by the CRCs only
            end else if (pos_reg < 32'd8) begin
                hlen_next = {hlen_reg[23:0], leaving};
                if (pos_reg == 32'd7) begin
                    pcalc_next = crc_next ^ esd_pkg::CRC_ALL_ONES;
                end
            end else if (pos_reg < esd_pkg::PRELUDE_LEN) begin
                precv_next = {precv_reg[23:0], leaving};
            end else if (rel < hlen_reg) begin
                unique case (phase_reg)
                    PH_NAME_LEN: begin
                        rem_next   = {8'd0, leaving};
                        phase_next = (leaving != 8'd0) ? PH_NAME : PH_TYPE;
                    end
                    PH_NAME: begin
                        byte_out           = 1'b1;
                        byte_res.kind      = esd_pkg::KIND_NAME;
                        byte_res.data      = leaving;
                        byte_res.field_end = (rem_reg == 16'd1);
                        rem_next           = rem_reg - 16'd1;
                        if (rem_reg == 16'd1) begin
                            phase_next = PH_TYPE;
                        end
                    end
                    PH_TYPE: begin
                        type_next  = leaving;
                        phase_next = PH_VLEN_HI;
                    end
                    PH_VLEN_HI: begin
                        rem_next   = {leaving, 8'd0};
                        phase_next = PH_VLEN_LO;
                    end
                    PH_VLEN_LO: begin
                        rem_next   = vlen;
                        phase_next = (vlen != 16'd0) ? PH_VALUE : PH_NAME_LEN;
                    end
                    PH_VALUE: begin
                        byte_out           = 1'b1;
                        byte_res.kind      = esd_pkg::KIND_VALUE;
                        byte_res.data      = leaving;
                        byte_res.hdr_type  = type_reg;
                        byte_res.field_end = (rem_reg == 16'd1);
                        rem_next           = rem_reg - 16'd1;
                        if (rem_reg == 16'd1) begin
                            phase_next = PH_NAME_LEN;
                        end
                    end
                    default: phase_next = PH_NAME_LEN;
                endcase
                // header region ends mid-header
                if ((rel == hlen_reg - 32'd1) && (phase_next != PH_NAME_LEN)) begin
                    herr_next = 1'b1;
                end
            end else begin
                byte_out      = 1'b1;
                byte_res.kind = esd_pkg::KIND_PAYLOAD;
                byte_res.data = leaving;
            end
            if (pos_reg != 32'hffff_ffff) begin
                pos_next = pos_reg + 32'd1;
            end
        end else begin
            win_next[fill_reg[1:0]] = data_byte;
            fill_next               = fill_reg + 3'd1;
        end
    end

    // End status, from the state as left by this item.
    always_comb begin
        size    = {1'b0, pos_next} + {30'd0, fill_next};
        hdr_end = {1'b0, esd_pkg::PRELUDE_LEN} + {1'b0, hlen_next};
        recv    = {win_next[0], win_next[1], win_next[2], win_next[3]};
        stat_res      = '0;
        stat_res.kind = esd_pkg::KIND_STATUS;
        stat_res.last = 1'b1;
        priority if (size < esd_pkg::MIN_MESSAGE_LEN) begin
            stat_res.status = esd_pkg::STATUS_SHORT;
        end else if (pcalc_next != precv_next) begin
            stat_res.status = esd_pkg::STATUS_PRELUDE;
        end else if (recv != (crc_next ^ esd_pkg::CRC_ALL_ONES)) begin
            stat_res.status = esd_pkg::STATUS_MSG_CRC;
        end else if (herr_next || ({1'b0, pos_next} < hdr_end)) begin
            stat_res.status = esd_pkg::STATUS_MALFORMED;
        end else begin
            stat_res.status = esd_pkg::STATUS_OK;
        end
    end

    always_comb begin
        push        = '0;
        push.first  = byte_out ? byte_res : stat_res;
        push.second = stat_res;
        if (accept) begin
            push.count = {1'b0, byte_out} + {1'b0, end_of_message};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (accept && end_of_message)) begin
            pos_reg   <= '0;
            win_reg   <= '{default: 8'd0};
            fill_reg  <= '0;
            crc_reg   <= esd_pkg::CRC_ALL_ONES;
            pcalc_reg <= '0;
            precv_reg <= '0;
            hlen_reg  <= '0;
            phase_reg <= PH_NAME_LEN;
            rem_reg   <= '0;
            type_reg  <= '0;
            herr_reg  <= 1'b0;
        end else if (accept) begin
            pos_reg   <= pos_next;
            win_reg   <= win_next;
            fill_reg  <= fill_next;
            crc_reg   <= crc_next;
            pcalc_reg <= pcalc_next;
            precv_reg <= precv_next;
            hlen_reg  <= hlen_next;
            phase_reg <= phase_next;
            rem_reg   <= rem_next;
            type_reg  <= type_next;
            herr_reg  <= herr_next;
        end
    end

endmodule

// ===== design/esd_result_fifo.sv =====
// Result queue taking up to two items a cycle and giving one while out_ready is high.
module esd_result_fifo #(
    parameter int DEPTH = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  esd_pkg::push_t   push,
    output logic             space_for_two,
    output logic             out_valid,
    input  logic             out_ready,
    output esd_pkg::result_t out_item
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    esd_pkg::result_t mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg,  count_next;
    logic [PW-1:0] wr_ptr1, wr_ptr2;
    logic          pop;

    always_comb begin
        pop     = out_valid && out_ready;
        wr_ptr1 = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        wr_ptr2 = (wr_ptr1 == PW'(DEPTH - 1)) ? '0 : wr_ptr1 + PW'(1);
        unique case (push.count)
            2'd1:    wr_ptr_next = wr_ptr1;
            2'd2:    wr_ptr_next = wr_ptr2;
            default: wr_ptr_next = wr_ptr_reg;
        endcase
        rd_ptr_next = rd_ptr_reg;
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        count_next = count_reg + CW'(push.count) - CW'(pop);
    end

    assign space_for_two = (count_reg <= CW'(DEPTH - 2));
    assign out_valid     = (count_reg != '0);
    assign out_item      = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) begin
            mem_reg[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2) begin
            mem_reg[wr_ptr1] <= push.second;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== design/event_stream_deframer.sv =====
// Top level of the event stream deframer: byte parser feeding a result queue.
// Results: an accepted item's results are queued and leave through m_ in order.
// Throughput: one item per cycle while two results fit; an end item with a byte
// result pushes two, and the FIFO_DEPTH-entry queue drains one per cycle on m_ready.
// Reset: synchronous active-low aresetn clears parser state and empties the queue.
`include "assert_macros.svh"
module event_stream_deframer #(
    parameter int FIFO_DEPTH = 4
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    input  logic       s_end_of_message,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_kind,
    output logic [7:0] m_out_byte,
    output logic [7:0] m_value_type,
    output logic       m_field_end,
    output logic [2:0] m_status,
    output logic       m_last
);

    // input item accepted this cycle
    logic             accept;
    esd_pkg::push_t   push;
    esd_pkg::result_t head;
    // head item decodes for the checks below
    logic             head_is_status;
    logic             head_status_ok;

    assign accept = s_valid && s_ready;

    // window, CRC and header tagging; state moves on with each item
    esd_parser u_parser (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .accept         (accept),
        .data_byte      (s_data_byte),
        .end_of_message (s_end_of_message),
        .push           (push)
    );

    // ready whenever the queue has room for the worst case of two results
    esd_result_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .push          (push),
        .space_for_two (s_ready),
        .out_valid     (m_valid),
        .out_ready     (m_ready),
        .out_item      (head)
    );

    assign m_kind       = head.kind;
    assign m_out_byte   = head.data;
    assign m_value_type = head.hdr_type;
    assign m_field_end  = head.field_end;
    assign m_status     = head.status;
    assign m_last       = head.last;

    assign head_is_status = (m_kind == esd_pkg::KIND_STATUS);
    assign head_status_ok = (m_status == esd_pkg::STATUS_OK);

    // status item is always the last of a message, and only it
    `ASSERT_IMPLIES(a_last_is_status, aclk, aresetn, m_valid, m_last == head_is_status)
    // byte items carry no status, status items no byte
    `ASSERT_IMPLIES(a_status_no_byte, aclk, aresetn, m_valid && m_last, m_out_byte == 8'd0)
    `ASSERT_IMPLIES(a_byte_no_status, aclk, aresetn, m_valid && !m_last, head_status_ok)
    // an accepted end item always leaves a result queued
    `ASSERT_NEXT(a_end_queued, aclk, aresetn, accept && s_end_of_message, m_valid)

endmodule
